// ----- rtl/line_rasterizer_with_depth_core_assert.svh -----
// Assertion macros for the line rasterizer with depth.
// Used by the checker module; depends on nothing else.
`ifndef LINE_RASTERIZER_WITH_DEPTH_CORE_ASSERT_SVH
`define LINE_RASTERIZER_WITH_DEPTH_CORE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define LRD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is also checked while reset is high.
`define LRD_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/lrd_pkg.sv -----
// Shared constants and types for the line rasterizer with depth.
// Used by the front queue, the back engine and the top level.
package lrd_pkg;
   localparam int COORD_BITS     = 12;
   localparam int ERR_BITS       = COORD_BITS + 3;
   localparam int DEPTH_BITS     = 32;
   localparam int COLOR_BITS     = 24;
   localparam int WIDTH_BITS     = 8;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   typedef struct packed {
      logic                         command;
      logic [COORD_BITS-1:0]        x_start;
      logic [COORD_BITS-1:0]        y_start;
      logic [COORD_BITS-1:0]        x_end;
      logic [COORD_BITS-1:0]        y_end;
      logic signed [DEPTH_BITS-1:0] z_start;
      logic signed [DEPTH_BITS-1:0] z_end;
      logic [COLOR_BITS-1:0]        color;
      logic [WIDTH_BITS-1:0]        width;
   } req_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } queue_head_type;
endpackage

// ----- rtl/lrd_front.sv -----
// Front part: accepts request items and holds them in a short queue.
// Depends on lrd_pkg.
module lrd_front #(
   parameter int QUEUE_DEPTH = lrd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  lrd_pkg::req_item_type in_item,
   output lrd_pkg::queue_head_type head,
   input  logic                  pop
);
   import lrd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   req_item_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, take;

   assign in_stall   = (count_ff == FULL_CNT);
   assign push       = in_valid && !in_stall;
   assign take       = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule

// ----- rtl/lrd_back.sv -----
// Back part: Bresenham stepping, depth setup divider and the result register.
// Depends on lrd_pkg; fed by lrd_front.
module lrd_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lrd_pkg::queue_head_type               head,
   output logic                                  pop,
   output logic                                  out_valid,
   input  logic                                  out_stall,
   output logic                                  out_pixel_valid,
   output logic [lrd_pkg::COORD_BITS-1:0]        out_x,
   output logic [lrd_pkg::COORD_BITS-1:0]        out_y,
   output logic signed [lrd_pkg::DEPTH_BITS-1:0] out_z,
   output logic [lrd_pkg::COLOR_BITS-1:0]        out_color,
   output logic [lrd_pkg::WIDTH_BITS-1:0]        out_width,
   output logic                                  out_last
);
   import lrd_pkg::*;

   localparam logic ST_RUN = 1'b0;
   localparam logic ST_DIV = 1'b1;
   localparam int   CNT_W  = $clog2(DEPTH_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DEPTH_BITS - 1);

   logic                         state_ff, state_in;
   logic                         busy_ff, busy_in;
   logic [COORD_BITS-1:0]        cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [ERR_BITS-1:0]   err_ff, err_in, inc_ax_ff, inc_ax_in;
   logic signed [ERR_BITS-1:0]   inc_dg_ff, inc_dg_in;
   logic                         xneg_ff, xneg_in, yneg_ff, yneg_in;
   logic                         majx_ff, majx_in;
   logic [COORD_BITS-1:0]        total_ff, total_in, count_ff, count_in;
   logic [DEPTH_BITS-1:0]        base_ff, base_in;
   logic                         zneg_ff, zneg_in;
   logic [DEPTH_BITS-1:0]        dvd_ff, dvd_in;
   logic [COORD_BITS-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [DEPTH_BITS-1:0]        qacc_ff, qacc_in;
   logic [COORD_BITS-1:0]        racc_ff, racc_in;
   logic [COLOR_BITS-1:0]        color_ff, color_in;
   logic [WIDTH_BITS-1:0]        width_ff, width_in;

   logic                         ov_ff, ov_in, opv_ff, opv_in, olast_ff, olast_in;
   logic [COORD_BITS-1:0]        ox_ff, ox_in, oy_ff, oy_in;
   logic [DEPTH_BITS-1:0]        oz_ff, oz_in;
   logic [COLOR_BITS-1:0]        oc_ff, oc_in;
   logic [WIDTH_BITS-1:0]        ow_ff, ow_in;

   logic                         out_free;
   logic [COORD_BITS-1:0]        dx, dy, maj, mnr, nx, ny, cnt_next;
   logic signed [DEPTH_BITS:0]   span;
   logic [DEPTH_BITS-1:0]        span_mag, qnew;
   logic [COORD_BITS:0]          rem_sh, rsum;
   logic                         dir_xn, dir_yn;

   assign out_free = !ov_ff || !out_stall;

   always_comb begin
      req_item_type it;
      it       = head.item;
      dir_xn   = it.x_end < it.x_start;
      dir_yn   = it.y_end < it.y_start;
      dx       = dir_xn ? it.x_start - it.x_end : it.x_end - it.x_start;
      dy       = dir_yn ? it.y_start - it.y_end : it.y_end - it.y_start;
      maj      = (dx > dy) ? dx : dy;
      mnr      = (dx > dy) ? dy : dx;
      span     = {it.z_end[DEPTH_BITS-1], it.z_end} - {it.z_start[DEPTH_BITS-1], it.z_start};
      span_mag = span[DEPTH_BITS] ? DEPTH_BITS'(-span) : span[DEPTH_BITS-1:0];
      rem_sh   = {rem_ff, dvd_ff[DEPTH_BITS-1]};
      cnt_next = count_ff + 1'b1;
      rsum     = {1'b0, racc_ff} + {1'b0, rem_ff};
      nx       = xneg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
      ny       = yneg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;

      state_in = state_ff;  busy_in = busy_ff;
      cur_x_in = cur_x_ff;  cur_y_in = cur_y_ff;
      err_in = err_ff;  inc_ax_in = inc_ax_ff;  inc_dg_in = inc_dg_ff;
      xneg_in = xneg_ff;  yneg_in = yneg_ff;  majx_in = majx_ff;
      total_in = total_ff;  count_in = count_ff;
      base_in = base_ff;  zneg_in = zneg_ff;
      dvd_in = dvd_ff;  rem_in = rem_ff;  cnt_in = cnt_ff;
      qacc_in = qacc_ff;  racc_in = racc_ff;
      color_in = color_ff;  width_in = width_ff;
      ov_in = ov_ff && out_stall;
      opv_in = opv_ff;  olast_in = olast_ff;
      ox_in = ox_ff;  oy_in = oy_ff;  oz_in = oz_ff;  oc_in = oc_ff;  ow_in = ow_ff;
      pop = 1'b0;
      qnew = qacc_ff;

      case (state_ff)
         ST_DIV: begin
            // Restoring division of the depth span by the step count.
            if (rem_sh >= {1'b0, total_ff}) begin
               rem_in = COORD_BITS'(rem_sh - {1'b0, total_ff});
               dvd_in = {dvd_ff[DEPTH_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[COORD_BITS-1:0];
               dvd_in = {dvd_ff[DEPTH_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (head.valid && out_free) begin
               pop   = 1'b1;
               ov_in = 1'b1;
               if (it.command == CMD_LOAD) begin
                  xneg_in   = dir_xn;
                  yneg_in   = dir_yn;
                  majx_in   = dx > dy;
                  inc_ax_in = ERR_BITS'({mnr, 1'b0});
                  inc_dg_in = ERR_BITS'({mnr, 1'b0}) - ERR_BITS'({maj, 1'b0});
                  err_in    = ERR_BITS'({mnr, 1'b0}) - ERR_BITS'(maj);
                  total_in  = maj;
                  count_in  = '0;
                  cur_x_in  = it.x_start;
                  cur_y_in  = it.y_start;
                  base_in   = it.z_start;
                  zneg_in   = span[DEPTH_BITS];
                  color_in  = it.color;
                  width_in  = it.width;
                  busy_in   = (maj != '0);
                  dvd_in    = span_mag;
                  rem_in    = '0;
                  cnt_in    = '0;
                  qacc_in   = '0;
                  racc_in   = '0;
                  if (maj != '0) begin
                     state_in = ST_DIV;
                  end
                  opv_in = 1'b1;  ox_in = it.x_start;  oy_in = it.y_start;
                  oz_in = it.z_start;  oc_in = it.color;  ow_in = it.width;
                  olast_in = (maj == '0);
               end else if (busy_ff) begin
                  // Depth moves by quotient each step, plus one on remainder carry.
                  if (rsum >= {1'b0, total_ff}) begin
                     racc_in = COORD_BITS'(rsum - {1'b0, total_ff});
                     qnew    = qacc_ff + dvd_ff + 1'b1;
                  end else begin
                     racc_in = rsum[COORD_BITS-1:0];
                     qnew    = qacc_ff + dvd_ff;
                  end
                  qacc_in = qnew;
                  if (err_ff[ERR_BITS-1]) begin
                     err_in = err_ff + inc_ax_ff;
                     if (majx_ff) begin
                        cur_x_in = nx;
                     end else begin
                        cur_y_in = ny;
                     end
                  end else begin
                     err_in   = err_ff + inc_dg_ff;
                     cur_x_in = nx;
                     cur_y_in = ny;
                  end
                  count_in = cnt_next;
                  busy_in  = cnt_next < total_ff;
                  opv_in   = 1'b1;
                  ox_in    = cur_x_in;
                  oy_in    = cur_y_in;
                  oz_in    = zneg_ff ? base_ff - qnew : base_ff + qnew;
                  oc_in    = color_ff;
                  ow_in    = width_ff;
                  olast_in = cnt_next >= total_ff;
               end else begin
                  opv_in = 1'b0;  ox_in = '0;  oy_in = '0;  oz_in = '0;
                  oc_in = '0;  ow_in = '0;  olast_in = 1'b0;
               end
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         busy_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;  cur_y_ff <= cur_y_in;
      err_ff <= err_in;  inc_ax_ff <= inc_ax_in;  inc_dg_ff <= inc_dg_in;
      xneg_ff <= xneg_in;  yneg_ff <= yneg_in;  majx_ff <= majx_in;
      total_ff <= total_in;  count_ff <= count_in;
      base_ff <= base_in;  zneg_ff <= zneg_in;
      dvd_ff <= dvd_in;  rem_ff <= rem_in;  cnt_ff <= cnt_in;
      qacc_ff <= qacc_in;  racc_ff <= racc_in;
      color_ff <= color_in;  width_ff <= width_in;
      opv_ff <= opv_in;  olast_ff <= olast_in;
      ox_ff <= ox_in;  oy_ff <= oy_in;  oz_ff <= oz_in;  oc_ff <= oc_in;  ow_ff <= ow_in;
   end

   assign out_valid       = ov_ff;
   assign out_pixel_valid = opv_ff;
   assign out_x           = ox_ff;
   assign out_y           = oy_ff;
   assign out_z           = oz_ff;
   assign out_color       = oc_ff;
   assign out_width       = ow_ff;
   assign out_last        = olast_ff;
endmodule

// ----- rtl/line_rasterizer_with_depth_core.sv -----
// Line rasterizer with depth: a Bresenham line generator with interpolated depth.
// Users send load and advance commands on the req_ channel; every command
// gives one result on the rsp_ channel. A load emits the first pixel of the
// segment, an advance emits the next one, or a result with pixel_valid low
// when no line is running. last_pixel marks the end point.
// An accepted item is first written into the queue; once it is at the head,
// its result is registered in the result register. Advances run at one item
// per cycle while no stalled result is pending. After a load of a segment
// with more than one point, the depth setup divider works one quotient bit
// per cycle before the next item is started.
// Requests wait in a small queue; req_stall rises when it is full.
// When rsp_stall is high with a result pending, the result holds and no new item is taken.
// Reset (synchronous, active high) empties the queue and drops any line.
// Depends on lrd_pkg, lrd_front and lrd_back.
module line_rasterizer_with_depth_core #(
   parameter int QUEUE_DEPTH = lrd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_command,
   input  logic [lrd_pkg::COORD_BITS-1:0]        req_x_start,
   input  logic [lrd_pkg::COORD_BITS-1:0]        req_y_start,
   input  logic [lrd_pkg::COORD_BITS-1:0]        req_x_end,
   input  logic [lrd_pkg::COORD_BITS-1:0]        req_y_end,
   input  logic signed [lrd_pkg::DEPTH_BITS-1:0] req_z_start,
   input  logic signed [lrd_pkg::DEPTH_BITS-1:0] req_z_end,
   input  logic [lrd_pkg::COLOR_BITS-1:0]        req_color_in,
   input  logic [lrd_pkg::WIDTH_BITS-1:0]        req_width_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_pixel_valid,
   output logic [lrd_pkg::COORD_BITS-1:0]        rsp_pixel_x,
   output logic [lrd_pkg::COORD_BITS-1:0]        rsp_pixel_y,
   output logic signed [lrd_pkg::DEPTH_BITS-1:0] rsp_pixel_z,
   output logic [lrd_pkg::COLOR_BITS-1:0]        rsp_color_out,
   output logic [lrd_pkg::WIDTH_BITS-1:0]        rsp_width_out,
   output logic                                  rsp_last_pixel
);
   import lrd_pkg::*;

   req_item_type   in_item;
   queue_head_type head;
   logic           pop;

   assign in_item.command = req_command;
   assign in_item.x_start = req_x_start;
   assign in_item.y_start = req_y_start;
   assign in_item.x_end   = req_x_end;
   assign in_item.y_end   = req_y_end;
   assign in_item.z_start = req_z_start;
   assign in_item.z_end   = req_z_end;
   assign in_item.color   = req_color_in;
   assign in_item.width   = req_width_in;

   lrd_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_item  (in_item),
      .head     (head),
      .pop      (pop)
   );

   lrd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .out_valid       (rsp_valid),
      .out_stall       (rsp_stall),
      .out_pixel_valid (rsp_pixel_valid),
      .out_x           (rsp_pixel_x),
      .out_y           (rsp_pixel_y),
      .out_z           (rsp_pixel_z),
      .out_color       (rsp_color_out),
      .out_width       (rsp_width_out),
      .out_last        (rsp_last_pixel)
   );
endmodule

// ----- rtl/lrd_checker.sv -----
// Port-level checks for the line rasterizer with depth, bound to the top level.
// Depends on line_rasterizer_with_depth_core_assert.svh.
`include "line_rasterizer_with_depth_core_assert.svh"

module lrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_pixel_valid,
   input logic [11:0] rsp_pixel_x,
   input logic [11:0] rsp_pixel_y,
   input logic [31:0] rsp_pixel_z,
   input logic        rsp_last_pixel
);
   // A stalled result must stay valid, with its x and depth held.
   `LRD_ASSERT_IMP(a_hold, clock, reset, rsp_valid && rsp_stall,
      ##1 (rsp_valid && $stable(rsp_pixel_z) && $stable(rsp_pixel_x)))
   // An empty result carries no coordinates, depth or end mark.
   `LRD_ASSERT_IMP(a_empty, clock, reset, rsp_valid && !rsp_pixel_valid,
      rsp_pixel_x == 12'd0 && rsp_pixel_y == 12'd0 && rsp_pixel_z == 32'd0 && !rsp_last_pixel)
   // The end mark only comes with a pixel.
   `LRD_ASSERT_IMP(a_last, clock, reset, rsp_valid && rsp_last_pixel, rsp_pixel_valid)
   // Reset leaves no result pending.
   `LRD_ASSERT_NEXT(a_reset, clock, reset, !rsp_valid)
endmodule

bind line_rasterizer_with_depth_core lrd_checker u_lrd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pixel_valid (rsp_pixel_valid),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_y     (rsp_pixel_y),
   .rsp_pixel_z     (rsp_pixel_z),
   .rsp_last_pixel  (rsp_last_pixel)
);
